### rtl/core/prc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plant reactive power controller package
// Shared widths, codes, the configuration record and Q16.16 helper functions.
// ----------------------------------------------------------------------------
package prc_pkg;

    // Field widths.
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned DT_W       = 31;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned REG_IDX_W  = 3;
    localparam int unsigned REG_DATA_W = 64;

    // Item modes.
    localparam logic MODE_INIT = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_NORMAL   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_HELD     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_REFERENCE_SELECT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FREEZE_VOLTAGE    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PI_GAINS          = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DEADBAND_EDGES    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ERROR_LIMITS      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_LIMITS     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INVERSE_FILTER    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_LAG_COEFFICIENTS  = 3'd7;

    // One in Q16.16, one bit wider than a word so that 1.0 - ratio fits.
    localparam logic signed [WORD_W:0] ONE_Q16 = 33'sd65536;

    localparam logic signed [WORD_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] Q16_MIN = 32'sh8000_0000;

    typedef logic signed [WORD_W-1:0] q16_t;

    // Configuration record as held by the register file.
    typedef struct packed {
        logic                ref_sel;
        q16_t                freeze_v;
        logic [WORD_W-1:0]   kp;
        logic [WORD_W-1:0]   ki;
        q16_t                db_lo;
        q16_t                db_hi;
        q16_t                e_min;
        q16_t                e_max;
        q16_t                q_min;
        q16_t                q_max;
        logic [DT_W-1:0]     inv_filt;
        logic [WORD_W-1:0]   lag_ratio;
        logic [WORD_W-1:0]   inv_lag;
    } prc_cfg_t;

    // Saturate a 33-bit signed value to the Q16.16 word range.
    function automatic q16_t sat_word(input logic signed [WORD_W:0] x);
        if (x[WORD_W] != x[WORD_W-1])
        begin
            return x[WORD_W] ? Q16_MIN : Q16_MAX;
        end
        return x[WORD_W-1:0];
    endfunction

    function automatic q16_t add_sat(input q16_t a, input q16_t b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        return sat_word(s);
    endfunction

    function automatic q16_t sub_sat(input q16_t a, input q16_t b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        return sat_word(s);
    endfunction

    // The lower limit is tested first, so inverted limits give the upper one
    // only when the value is not below the lower one.
    function automatic q16_t clamp_q(input q16_t v, input q16_t lo, input q16_t hi);
        if (v < lo)
        begin
            return lo;
        end
        if (hi < v)
        begin
            return hi;
        end
        return v;
    endfunction

    // Deadband: the upper edge wins when the edges are inverted.
    function automatic q16_t deadband_q(input q16_t raw, input q16_t lo, input q16_t hi);
        if (raw > hi)
        begin
            return sub_sat(raw, hi);
        end
        if (raw < lo)
        begin
            return sub_sat(raw, lo);
        end
        return '0;
    endfunction

endpackage

### rtl/core/prc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plant reactive power controller channels
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------

// Input item channel.
interface prc_item_if;
    logic                valid;
    logic                ready;
    logic                mode;
    logic [30:0]         delta_time;
    logic signed [31:0]  terminal_voltage;
    logic signed [31:0]  reactive_power;

    modport source (output valid, mode, delta_time, terminal_voltage, reactive_power,
                    input ready);
    modport sink   (input valid, mode, delta_time, terminal_voltage, reactive_power,
                    output ready);
endinterface

// Result channel.
interface prc_result_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  reactive_increment;
    logic [1:0]          status;

    modport source (output valid, reactive_increment, status, input ready);
    modport sink   (input valid, reactive_increment, status, output ready);
endinterface

// Register write channel.
interface prc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/prc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared Q16.16 multiplier
// Registers the full signed product; the floor scaling by 2^-16 and the
// saturation to one word are applied on the registered product.
// ----------------------------------------------------------------------------
module prc_mul
    import prc_pkg::*;
(
    input  logic                    clk,
    input  logic signed [WORD_W:0]  op_a,
    input  q16_t                    op_b,
    output q16_t                    prod
);

    logic signed [2*WORD_W:0]        prod_reg;
    logic signed [2*WORD_W-16:0]     scaled;
    logic                            ovf;

    // Product register; operand one is 33 bits so unsigned words fit.
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    // Dropping the low fraction bits floors toward minus infinity.
    assign scaled = prod_reg[2*WORD_W:16];

    // Overflow when the bits above the word are not all copies of the sign.
    assign ovf = !((&scaled[2*WORD_W-16:WORD_W-1]) || !(|scaled[2*WORD_W-16:WORD_W-1]));

    assign prod = ovf ? (scaled[2*WORD_W-16] ? Q16_MIN : Q16_MAX) : scaled[WORD_W-1:0];

endmodule

### rtl/core/prc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plant reactive power controller register file
// Holds the eight configuration registers written over the register channel.
// ----------------------------------------------------------------------------
module prc_regs
    import prc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    prc_cfg_if.sink    cfg,
    output prc_cfg_t   regs
);

    prc_cfg_t cfg_reg;
    prc_cfg_t cfg_next;

    // The register file takes a write in every cycle.
    assign cfg.ready = 1'b1;

    // Decode one write beat into the register record.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_REFERENCE_SELECT: cfg_next.ref_sel = cfg.data[0];
                REG_FREEZE_VOLTAGE:   cfg_next.freeze_v = cfg.data[WORD_W-1:0];
                REG_PI_GAINS:
                begin
                    cfg_next.kp = cfg.data[WORD_W-1:0];
                    cfg_next.ki = cfg.data[REG_DATA_W-1:WORD_W];
                end
                REG_DEADBAND_EDGES:
                begin
                    cfg_next.db_lo = cfg.data[WORD_W-1:0];
                    cfg_next.db_hi = cfg.data[REG_DATA_W-1:WORD_W];
                end
                REG_ERROR_LIMITS:
                begin
                    cfg_next.e_min = cfg.data[WORD_W-1:0];
                    cfg_next.e_max = cfg.data[REG_DATA_W-1:WORD_W];
                end
                REG_OUTPUT_LIMITS:
                begin
                    cfg_next.q_min = cfg.data[WORD_W-1:0];
                    cfg_next.q_max = cfg.data[REG_DATA_W-1:WORD_W];
                end
                REG_INVERSE_FILTER:   cfg_next.inv_filt = cfg.data[DT_W-1:0];
                REG_LAG_COEFFICIENTS:
                begin
                    cfg_next.lag_ratio = cfg.data[WORD_W-1:0];
                    cfg_next.inv_lag   = cfg.data[REG_DATA_W-1:WORD_W];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign regs = cfg_reg;

endmodule

### rtl/core/prc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plant reactive power controller sequencer
// On a tick, steps the states through one shared multiplier: error, PI sum,
// filter, integrator and lag updates, a second error and PI pass on the new
// states, then the lead-lag increment. Holds the result in an output register.
// ----------------------------------------------------------------------------
module prc_core
    import prc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  prc_cfg_t       cfg_q,
    prc_item_if.sink       item,
    prc_result_if.source   result
);

    // Sequencer steps.
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_E1   = 5'd1;
    localparam logic [4:0] S_E2   = 5'd2;
    localparam logic [4:0] S_K1   = 5'd3;
    localparam logic [4:0] S_K2   = 5'd4;
    localparam logic [4:0] S_K3   = 5'd5;
    localparam logic [4:0] S_CL   = 5'd6;
    localparam logic [4:0] S_F1   = 5'd7;
    localparam logic [4:0] S_F2   = 5'd8;
    localparam logic [4:0] S_F3   = 5'd9;
    localparam logic [4:0] S_F4   = 5'd10;
    localparam logic [4:0] S_F5   = 5'd11;
    localparam logic [4:0] S_F6   = 5'd12;
    localparam logic [4:0] S_F7   = 5'd13;
    localparam logic [4:0] S_F8   = 5'd14;
    localparam logic [4:0] S_L1   = 5'd15;
    localparam logic [4:0] S_L2   = 5'd16;
    localparam logic [4:0] S_L3   = 5'd17;
    localparam logic [4:0] S_DONE = 5'd18;

    logic [4:0]            state_reg, state_next;
    logic                  pass_reg, pass_next;
    logic [DT_W-1:0]       dt_reg, dt_next;
    q16_t                  v_reg, v_next;
    q16_t                  q_reg, q_next;
    q16_t                  vf_reg, vf_next;
    q16_t                  qf_reg, qf_next;
    q16_t                  integ_reg, integ_next;
    q16_t                  lag_reg, lag_next;
    q16_t                  vref_reg, vref_next;
    q16_t                  qref_reg, qref_next;
    q16_t                  raw_reg, raw_next;
    logic                  frz_reg, frz_next;
    q16_t                  err_reg, err_next;
    q16_t                  acc_reg, acc_next;
    q16_t                  pi_reg, pi_next;
    logic                  hold_reg, hold_next;
    q16_t                  t0_reg, t0_next;
    q16_t                  t1_reg, t1_next;
    q16_t                  t2_reg, t2_next;
    q16_t                  res_inc_reg, res_inc_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    q16_t                  out_inc_reg, out_inc_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;

    logic signed [WORD_W:0] mul_a;
    q16_t                   mul_b;
    q16_t                   mul_p;
    q16_t                   comp_ratio;
    logic                   item_acc;

    prc_mul u_mul
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    assign item_acc   = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);

    // Weight of the lag term, saturated when the lead ratio exceeds 32769.0.
    assign comp_ratio = sat_word(ONE_Q16 - {1'b0, cfg_q.lag_ratio});

    // Sequencer and datapath. A product issued in one step is used in the next.
    always_comb
    begin
        state_next      = state_reg;
        pass_next       = pass_reg;
        dt_next         = dt_reg;
        v_next          = v_reg;
        q_next          = q_reg;
        vf_next         = vf_reg;
        qf_next         = qf_reg;
        integ_next      = integ_reg;
        lag_next        = lag_reg;
        vref_next       = vref_reg;
        qref_next       = qref_reg;
        raw_next        = raw_reg;
        frz_next        = frz_reg;
        err_next        = err_reg;
        acc_next        = acc_reg;
        pi_next         = pi_reg;
        hold_next       = hold_reg;
        t0_next         = t0_reg;
        t1_next         = t1_reg;
        t2_next         = t2_reg;
        res_inc_next    = res_inc_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_inc_next    = out_inc_reg;
        out_status_next = out_status_reg;
        mul_a           = '0;
        mul_b           = '0;

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    dt_next   = item.delta_time;
                    v_next    = item.terminal_voltage;
                    q_next    = item.reactive_power;
                    pass_next = 1'b0;
                    hold_next = 1'b0;
                    if (item.mode == MODE_TICK)
                    begin
                        state_next = S_E1;
                    end
                    else if (item.terminal_voltage <= 0)
                    begin
                        res_inc_next    = '0;
                        res_status_next = STATUS_REJECTED;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        vref_next       = item.terminal_voltage;
                        qref_next       = item.reactive_power;
                        vf_next         = item.terminal_voltage;
                        qf_next         = item.reactive_power;
                        integ_next      = '0;
                        lag_next        = '0;
                        res_inc_next    = '0;
                        res_status_next = STATUS_NORMAL;
                        state_next      = S_DONE;
                    end
                end
            end
            // Raw error from the selected reference and the freeze test.
            S_E1:
            begin
                raw_next   = cfg_q.ref_sel ? sub_sat(vref_reg, vf_reg)
                                           : sub_sat(qref_reg, qf_reg);
                frz_next   = (v_reg < cfg_q.freeze_v);
                state_next = S_E2;
            end
            // Deadband and error limits.
            S_E2:
            begin
                err_next   = frz_reg ? q16_t'(0)
                           : clamp_q(deadband_q(raw_reg, cfg_q.db_lo, cfg_q.db_hi),
                                     cfg_q.e_min, cfg_q.e_max);
                state_next = S_K1;
            end
            // Proportional and integral products, then their sum.
            S_K1:
            begin
                mul_a      = {1'b0, cfg_q.kp};
                mul_b      = err_reg;
                state_next = S_K2;
            end
            S_K2:
            begin
                mul_a      = {1'b0, cfg_q.ki};
                mul_b      = integ_reg;
                acc_next   = mul_p;
                state_next = S_K3;
            end
            S_K3:
            begin
                acc_next   = add_sat(acc_reg, mul_p);
                state_next = S_CL;
            end
            // Output limits; anti-windup is decided on the first pass only.
            S_CL:
            begin
                pi_next = clamp_q(acc_reg, cfg_q.q_min, cfg_q.q_max);
                if (!pass_reg)
                begin
                    hold_next  = (acc_reg >= cfg_q.q_max && err_reg > 0) ||
                                 (acc_reg <= cfg_q.q_min && err_reg < 0);
                    state_next = S_F1;
                end
                else
                begin
                    state_next = S_L1;
                end
            end
            // State derivatives.
            S_F1:
            begin
                mul_a      = {2'b00, cfg_q.inv_filt};
                mul_b      = sub_sat(v_reg, vf_reg);
                state_next = S_F2;
            end
            S_F2:
            begin
                mul_a      = {2'b00, cfg_q.inv_filt};
                mul_b      = sub_sat(q_reg, qf_reg);
                t0_next    = mul_p;
                state_next = S_F3;
            end
            S_F3:
            begin
                mul_a      = {1'b0, cfg_q.inv_lag};
                mul_b      = sub_sat(pi_reg, lag_reg);
                t1_next    = mul_p;
                state_next = S_F4;
            end
            // Forward-Euler updates.
            S_F4:
            begin
                mul_a      = {2'b00, dt_reg};
                mul_b      = t0_reg;
                t2_next    = mul_p;
                state_next = S_F5;
            end
            S_F5:
            begin
                mul_a      = {2'b00, dt_reg};
                mul_b      = t1_reg;
                vf_next    = add_sat(vf_reg, mul_p);
                state_next = S_F6;
            end
            S_F6:
            begin
                mul_a      = {2'b00, dt_reg};
                mul_b      = hold_reg ? q16_t'(0) : err_reg;
                qf_next    = add_sat(qf_reg, mul_p);
                state_next = S_F7;
            end
            S_F7:
            begin
                mul_a      = {2'b00, dt_reg};
                mul_b      = t2_reg;
                integ_next = add_sat(integ_reg, mul_p);
                state_next = S_F8;
            end
            S_F8:
            begin
                lag_next   = add_sat(lag_reg, mul_p);
                pass_next  = 1'b1;
                state_next = S_E1;
            end
            // Lead-lag increment from the updated states.
            S_L1:
            begin
                mul_a      = {1'b0, cfg_q.lag_ratio};
                mul_b      = pi_reg;
                state_next = S_L2;
            end
            S_L2:
            begin
                mul_a      = {comp_ratio[WORD_W-1], comp_ratio};
                mul_b      = lag_reg;
                acc_next   = mul_p;
                state_next = S_L3;
            end
            S_L3:
            begin
                res_inc_next    = add_sat(acc_reg, mul_p);
                res_status_next = hold_reg ? STATUS_HELD : STATUS_NORMAL;
                state_next      = S_DONE;
            end
            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_inc_next    = res_inc_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pass_reg       <= 1'b0;
            dt_reg         <= '0;
            v_reg          <= '0;
            q_reg          <= '0;
            vf_reg         <= '0;
            qf_reg         <= '0;
            integ_reg      <= '0;
            lag_reg        <= '0;
            vref_reg       <= '0;
            qref_reg       <= '0;
            raw_reg        <= '0;
            frz_reg        <= 1'b0;
            err_reg        <= '0;
            acc_reg        <= '0;
            pi_reg         <= '0;
            hold_reg       <= 1'b0;
            t0_reg         <= '0;
            t1_reg         <= '0;
            t2_reg         <= '0;
            res_inc_reg    <= '0;
            res_status_reg <= STATUS_NORMAL;
            out_valid_reg  <= 1'b0;
            out_inc_reg    <= '0;
            out_status_reg <= STATUS_NORMAL;
        end
        else
        begin
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            dt_reg         <= dt_next;
            v_reg          <= v_next;
            q_reg          <= q_next;
            vf_reg         <= vf_next;
            qf_reg         <= qf_next;
            integ_reg      <= integ_next;
            lag_reg        <= lag_next;
            vref_reg       <= vref_next;
            qref_reg       <= qref_next;
            raw_reg        <= raw_next;
            frz_reg        <= frz_next;
            err_reg        <= err_next;
            acc_reg        <= acc_next;
            pi_reg         <= pi_next;
            hold_reg       <= hold_next;
            t0_reg         <= t0_next;
            t1_reg         <= t1_next;
            t2_reg         <= t2_next;
            res_inc_reg    <= res_inc_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_inc_reg    <= out_inc_next;
            out_status_reg <= out_status_next;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.reactive_increment = out_inc_reg;
    assign result.status             = out_status_reg;

    // A tick beat always starts the error step.
    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.mode == MODE_TICK) |=> (state_reg == S_E1))
        else $error("tick beat did not start the error step");

    // A new result only appears out of the hand-off step.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the hand-off step");

    // The lead-lag steps only run on the second pass.
    a_lead_lag_second_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_L1 || state_reg == S_L2 || state_reg == S_L3) |-> pass_reg)
        else $error("lead-lag step reached on the first pass");

    // Controller states hold while no item is in work.
    a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !(item.valid && item.ready))
        |=> ($stable(integ_reg) && $stable(lag_reg) && $stable(vf_reg) && $stable(qf_reg)))
        else $error("controller state changed while idle");

endmodule

### rtl/core/plant_reactive_power_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plant reactive power controller
// Q16.16 plant-level reactive power controller: measurement filters, PI with
// anti-windup, lag and lead-lag increment, one result beat per item beat.
// ----------------------------------------------------------------------------
// An init or a rejected init item goes straight to the hand-off step; a tick
// runs 13 products and two error and PI passes in sequence through the single
// shared multiplier. The sequencer returns to idle as the result enters the
// output register, and only then takes the next item beat. The output register
// holds a result while the sink stalls. Reset clears all states, the register
// file and the output register, but not the multiplier's product register.
// ----------------------------------------------------------------------------
module plant_reactive_power_controller
    import prc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    prc_item_if.sink      item,
    prc_result_if.source  result,
    prc_cfg_if.sink       cfg
);

    prc_cfg_t cfg_q;

    // Configuration register file.
    prc_regs u_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_q)
    );

    // Sequencer with the shared multiplier.
    prc_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_q  (cfg_q),
        .item   (item),
        .result (result)
    );

endmodule

### tb/sv/plant_reactive_power_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plant reactive power controller testbench
// Drives init and tick beats under several register settings, from nominal
// loops to all-zero, all-one, inverted and random settings. Each accepted
// beat goes through a Q16.16 controller model kept here, and every result
// beat is checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module plant_reactive_power_controller_tb;
    import prc_pkg::*;

    localparam longint SAT_HI   = 64'sd2147483647;
    localparam longint SAT_LO   = -64'sd2147483648;
    localparam longint Q_ONE    = 64'sd65536;
    localparam int     PHASES   = 7;
    localparam int     PHASE_ITEMS = 155;
    localparam logic [DT_W-1:0] DT_MAX = {DT_W{1'b1}};

    typedef struct packed {
        logic              mode;
        logic [DT_W-1:0]   dt;
        q16_t              volt;
        q16_t              reac;
    } ctl_item_t;

    typedef struct packed {
        q16_t                increment;
        logic [STATUS_W-1:0] status;
    } ctl_result_t;

    logic clk = 1'b0;
    logic rst_n;

    prc_item_if   item_ch ();
    prc_result_if result_ch ();
    prc_cfg_if    cfg_ch ();

    plant_reactive_power_controller DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Clock generation.
    always
    begin
        #5;
        clk = ~clk;
    end

    // Controller model state and its copy of the registers.
    prc_cfg_t    ctl_cfg = '0;
    longint      volt_filt = 0;
    longint      reac_filt = 0;
    longint      integ = 0;
    longint      lag_q = 0;
    longint      volt_ref = 0;
    longint      reac_ref = 0;

    ctl_item_t   pending_items [$];
    ctl_result_t expected_results [$];
    logic [63:0] phase_regs [8];
    int          mismatch_count = 0;

    // Saturate to the Q16.16 word range.
    function automatic longint clip_q(input longint x);
        if (x > SAT_HI)
        begin
            return SAT_HI;
        end
        if (x < SAT_LO)
        begin
            return SAT_LO;
        end
        return x;
    endfunction

    // Q16.16 product, rounded toward minus infinity.
    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clip_q(p >>> 16);
    endfunction

    // The lower bound is tested first, which decides inverted limits.
    function automatic longint limit_q(input longint v, input longint lo, input longint hi);
        if (v < lo)
        begin
            return lo;
        end
        if (hi < v)
        begin
            return hi;
        end
        return v;
    endfunction

    // Error after freeze, deadband and clamp, from the current filter states.
    function automatic longint control_error(input longint v);
        longint raw;
        longint lo;
        longint hi;
        longint d;
        d = 0;
        if (v < longint'($signed(ctl_cfg.freeze_v)))
        begin
            return 0;
        end
        raw = ctl_cfg.ref_sel ? clip_q(volt_ref - volt_filt) : clip_q(reac_ref - reac_filt);
        lo = longint'($signed(ctl_cfg.db_lo));
        hi = longint'($signed(ctl_cfg.db_hi));
        if (raw > hi)
        begin
            d = clip_q(raw - hi);
        end
        else if (raw < lo)
        begin
            d = clip_q(raw - lo);
        end
        return limit_q(d, longint'($signed(ctl_cfg.e_min)), longint'($signed(ctl_cfg.e_max)));
    endfunction

    function automatic longint pi_sum(input longint err);
        return clip_q(qmul(longint'(ctl_cfg.kp), err) + qmul(longint'(ctl_cfg.ki), integ));
    endfunction

    // One controller step: returns the result and advances the model state.
    function automatic ctl_result_t predict_beat(input ctl_item_t it);
        ctl_result_t res;
        longint dt;
        longint v;
        longint q;
        longint qmin;
        longint qmax;
        longint inv_f;
        longint ratio;
        longint inv_v;
        longint err;
        longint raw;
        longint piv;
        longint rv;
        longint rq;
        longint ri;
        longint rl;
        logic   held;
        dt = longint'(it.dt);
        v = longint'($signed(it.volt));
        q = longint'($signed(it.reac));
        qmin = longint'($signed(ctl_cfg.q_min));
        qmax = longint'($signed(ctl_cfg.q_max));
        inv_f = longint'(ctl_cfg.inv_filt);
        ratio = longint'(ctl_cfg.lag_ratio);
        inv_v = longint'(ctl_cfg.inv_lag);
        res.increment = '0;
        res.status = STATUS_NORMAL;

        if (it.mode == MODE_INIT)
        begin
            // A non-positive voltage leaves every state alone.
            if (v <= 0)
            begin
                res.status = STATUS_REJECTED;
                return res;
            end
            volt_ref = v;
            reac_ref = q;
            volt_filt = v;
            reac_filt = q;
            integ = 0;
            lag_q = 0;
            return res;
        end

        err = control_error(v);
        raw = pi_sum(err);
        held = (raw >= qmax && err > 0) || (raw <= qmin && err < 0);
        piv = limit_q(raw, qmin, qmax);
        rv = qmul(inv_f, clip_q(v - volt_filt));
        rq = qmul(inv_f, clip_q(q - reac_filt));
        ri = held ? 0 : err;
        rl = qmul(inv_v, clip_q(piv - lag_q));

        volt_filt = clip_q(volt_filt + qmul(dt, rv));
        reac_filt = clip_q(reac_filt + qmul(dt, rq));
        integ = clip_q(integ + qmul(dt, ri));
        lag_q = clip_q(lag_q + qmul(dt, rl));

        // The increment uses the new states and the same voltage.
        err = control_error(v);
        piv = limit_q(pi_sum(err), qmin, qmax);
        res.increment = q16_t'(clip_q(qmul(ratio, piv) + qmul(clip_q(Q_ONE - ratio), lag_q)));
        res.status = held ? STATUS_HELD : STATUS_NORMAL;
        return res;
    endfunction

    // Update the model copy of one register.
    function automatic void apply_register(input logic [REG_IDX_W-1:0] idx,
                                           input logic [REG_DATA_W-1:0] val);
        case (idx)
            REG_REFERENCE_SELECT: ctl_cfg.ref_sel = val[0];
            REG_FREEZE_VOLTAGE:   ctl_cfg.freeze_v = val[31:0];
            REG_PI_GAINS:
            begin
                ctl_cfg.kp = val[31:0];
                ctl_cfg.ki = val[63:32];
            end
            REG_DEADBAND_EDGES:
            begin
                ctl_cfg.db_lo = val[31:0];
                ctl_cfg.db_hi = val[63:32];
            end
            REG_ERROR_LIMITS:
            begin
                ctl_cfg.e_min = val[31:0];
                ctl_cfg.e_max = val[63:32];
            end
            REG_OUTPUT_LIMITS:
            begin
                ctl_cfg.q_min = val[31:0];
                ctl_cfg.q_max = val[63:32];
            end
            REG_INVERSE_FILTER:   ctl_cfg.inv_filt = val[DT_W-1:0];
            REG_LAG_COEFFICIENTS:
            begin
                ctl_cfg.lag_ratio = val[31:0];
                ctl_cfg.inv_lag = val[63:32];
            end
            default: ;
        endcase
    endfunction

    function automatic logic [63:0] word_pair(input int lo_word, input int hi_word);
        return {hi_word, lo_word};
    endfunction

    function automatic int pick_range(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
        mismatch_count++;
        $display("%0t ns: mismatch on %s: got %0d, expected %0d",
                 $time, what, got_v, want_v);
    endtask

    task automatic push_item(input logic m, input logic [DT_W-1:0] dt, input int v, input int q);
        ctl_item_t it;
        it.mode = m;
        it.dt = dt;
        it.volt = v;
        it.reac = q;
        pending_items.push_back(it);
    endtask

    // Register write: the beat is taken at an edge with valid and ready high.
    // The caller lowers valid after the last write of a group.
    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [REG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk);
        while (!cfg_ch.ready);
        apply_register(idx, val);
    endtask

    task automatic program_registers();
        write_register(REG_REFERENCE_SELECT, phase_regs[REG_REFERENCE_SELECT]);
        write_register(REG_FREEZE_VOLTAGE, phase_regs[REG_FREEZE_VOLTAGE]);
        write_register(REG_PI_GAINS, phase_regs[REG_PI_GAINS]);
        write_register(REG_DEADBAND_EDGES, phase_regs[REG_DEADBAND_EDGES]);
        write_register(REG_ERROR_LIMITS, phase_regs[REG_ERROR_LIMITS]);
        write_register(REG_OUTPUT_LIMITS, phase_regs[REG_OUTPUT_LIMITS]);
        write_register(REG_INVERSE_FILTER, phase_regs[REG_INVERSE_FILTER]);
        write_register(REG_LAG_COEFFICIENTS, phase_regs[REG_LAG_COEFFICIENTS]);
        cfg_ch.valid <= 1'b0;
    endtask

    // Register settings of each phase of the run.
    task automatic build_phase_settings(input int ph);
        case (ph)
            0:
            begin
                // Reactive regulation with ordinary loop constants.
                phase_regs[REG_REFERENCE_SELECT] = 64'd0;
                phase_regs[REG_FREEZE_VOLTAGE]   = 64'd32768;
                phase_regs[REG_PI_GAINS]         = word_pair(65536, 5 * 65536);
                phase_regs[REG_DEADBAND_EDGES]   = word_pair(-655, 655);
                phase_regs[REG_ERROR_LIMITS]     = word_pair(-32768, 32768);
                phase_regs[REG_OUTPUT_LIMITS]    = word_pair(-26214, 26214);
                phase_regs[REG_INVERSE_FILTER]   = 64'd3276800;
                phase_regs[REG_LAG_COEFFICIENTS] = word_pair(32768, 20 * 65536);
            end
            1:
            begin
                // Voltage regulation with tight output limits, so the
                // anti-windup hold engages often.
                phase_regs[REG_REFERENCE_SELECT] = 64'd1;
                phase_regs[REG_FREEZE_VOLTAGE]   = 64'd52429;
                phase_regs[REG_PI_GAINS]         = word_pair(2 * 65536, 10 * 65536);
                phase_regs[REG_DEADBAND_EDGES]   = word_pair(-328, 328);
                phase_regs[REG_ERROR_LIMITS]     = word_pair(-13107, 13107);
                phase_regs[REG_OUTPUT_LIMITS]    = word_pair(-3277, 3277);
                phase_regs[REG_INVERSE_FILTER]   = 64'd1966080;
                phase_regs[REG_LAG_COEFFICIENTS] = word_pair(16384, 10 * 65536);
            end
            2:
            begin
                // Everything zero, with the highest freeze voltage.
                foreach (phase_regs[r])
                begin
                    phase_regs[r] = '0;
                end
                phase_regs[REG_FREEZE_VOLTAGE] = 64'h0000_0000_7FFF_FFFF;
            end
            3:
            begin
                foreach (phase_regs[r])
                begin
                    phase_regs[r] = '1;
                end
            end
            4:
            begin
                // Inverted deadband and limits, lead ratio above one.
                phase_regs[REG_REFERENCE_SELECT] = 64'd0;
                phase_regs[REG_FREEZE_VOLTAGE]   = 64'h0000_0000_8000_0000;
                phase_regs[REG_PI_GAINS]         = word_pair(32768, 2 * 65536);
                phase_regs[REG_DEADBAND_EDGES]   = word_pair(655, -655);
                phase_regs[REG_ERROR_LIMITS]     = word_pair(19661, -19661);
                phase_regs[REG_OUTPUT_LIMITS]    = word_pair(13107, -13107);
                phase_regs[REG_INVERSE_FILTER]   = 64'd1310720;
                phase_regs[REG_LAG_COEFFICIENTS] = word_pair(98304, 5 * 65536);
            end
            5:
            begin
                foreach (phase_regs[r])
                begin
                    phase_regs[r] = {$urandom, $urandom};
                end
            end
            default:
            begin
                // Random settings of a plausible size.
                phase_regs[REG_REFERENCE_SELECT] = 64'($urandom_range(0, 1));
                phase_regs[REG_FREEZE_VOLTAGE]   = word_pair(pick_range(0, 65536), 0);
                phase_regs[REG_PI_GAINS]         = word_pair(pick_range(0, 4 * 65536),
                                                             pick_range(0, 20 * 65536));
                phase_regs[REG_DEADBAND_EDGES]   = word_pair(pick_range(-3000, 500),
                                                             pick_range(-500, 3000));
                phase_regs[REG_ERROR_LIMITS]     = word_pair(pick_range(-40000, 5000),
                                                             pick_range(-5000, 40000));
                phase_regs[REG_OUTPUT_LIMITS]    = word_pair(pick_range(-30000, 3000),
                                                             pick_range(-3000, 30000));
                phase_regs[REG_INVERSE_FILTER]   = word_pair(pick_range(0, 100 * 65536), 0);
                phase_regs[REG_LAG_COEFFICIENTS] = word_pair(pick_range(0, 131072),
                                                             pick_range(0, 50 * 65536));
            end
        endcase
    endtask

    // Directed beats: rejected inits, zero time, freeze, hold, field extremes.
    task automatic queue_directed_items();
        push_item(MODE_INIT, 31'd655, 0, 13107);
        push_item(MODE_INIT, 31'd655, Q16_MIN, Q16_MAX);
        push_item(MODE_TICK, 31'd0, 65536, 0);
        push_item(MODE_INIT, 31'd0, 65536, 13107);
        push_item(MODE_TICK, 31'd0, 65536, 13107);
        push_item(MODE_TICK, 31'd655, 66847, 6554);
        push_item(MODE_TICK, 31'd655, 65536, 13500);
        push_item(MODE_TICK, 31'd655, 19661, 6554);
        // Drive the reactive filter away from its reference until the
        // integrator is held, then back the other way.
        for (int k = 0; k < 6; k++)
        begin
            push_item(MODE_TICK, 31'd655, 65536, -65536);
        end
        push_item(MODE_TICK, 31'd655, 65536, 65536);
        push_item(MODE_TICK, 31'd655, 65536, 65536);
        push_item(MODE_TICK, DT_MAX, 65536, Q16_MAX);
        push_item(MODE_TICK, 31'd655, Q16_MAX, Q16_MIN);
        push_item(MODE_TICK, 31'd1, Q16_MIN, 0);
        push_item(MODE_INIT, 31'd655, Q16_MAX, Q16_MIN);
        push_item(MODE_TICK, DT_MAX, Q16_MIN, Q16_MAX);
        push_item(MODE_INIT, 31'd0, 1, Q16_MAX);
        push_item(MODE_TICK, 31'd100, 1, 0);
    endtask

    // Mostly an init followed by a run of ticks near its operating point,
    // with some rejected inits and fully random beats mixed in.
    task automatic queue_random_items(input int count);
        int queued;
        int pick;
        int v0;
        int q0;
        int run;
        int v;
        int q;
        logic [DT_W-1:0] dt;
        queued = 0;
        while (queued < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                push_item(logic'($urandom_range(0, 1)), DT_W'($urandom), $urandom, $urandom);
                queued++;
            end
            else if (pick < 20)
            begin
                push_item(MODE_INIT, DT_W'($urandom), -pick_range(0, 4 * 65536), $urandom);
                queued++;
            end
            else
            begin
                v0 = pick_range(55000, 76000);
                q0 = pick_range(-32768, 32768);
                push_item(MODE_INIT, DT_W'($urandom), v0, q0);
                queued++;
                run = $urandom_range(4, 40);
                for (int k = 0; k < run && queued < count; k++)
                begin
                    pick = $urandom_range(0, 99);
                    v = (pick < 10) ? pick_range(0, v0 / 2) : v0 + pick_range(-3000, 3000);
                    q = q0 + pick_range(-40000, 40000);
                    pick = $urandom_range(0, 99);
                    if (pick < 5)
                    begin
                        dt = '0;
                    end
                    else if (pick < 10)
                    begin
                        dt = DT_W'(pick_range(1500, 65536));
                    end
                    else
                    begin
                        dt = DT_W'(pick_range(1, 1500));
                    end
                    push_item(MODE_TICK, dt, v, q);
                    queued++;
                end
            end
        end
    endtask

    // Sample after the edge has settled so the queues and valid agree.
    task automatic wait_for_drain();
        do @(negedge clk);
        while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0);
    endtask

    // Item driver: bursts of random length separated by random gaps.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    ctl_item_t   offer_item;

    always @(posedge clk)
    begin
        if (rst_n && (!item_ch.valid || item_ch.ready))
        begin
            if (gap_left == 0 && pending_items.size() != 0)
            begin
                offer_item = pending_items.pop_front();
                item_ch.valid            <= 1'b1;
                item_ch.mode             <= offer_item.mode;
                item_ch.delta_time       <= offer_item.dt;
                item_ch.terminal_voltage <= offer_item.volt;
                item_ch.reactive_power   <= offer_item.reac;
                if (burst_left <= 1)
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                item_ch.valid <= 1'b0;
                if (gap_left != 0)
                begin
                    gap_left--;
                end
            end
        end
    end

    // Result receiver: the stall style changes at random intervals, and
    // twice a long hold-off backs the block up into its input.
    int unsigned rx_style = 0;
    int unsigned rx_phase_left = 0;
    int unsigned rx_hold_left = 0;
    int unsigned rx_beats = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                rx_beats++;
                if (rx_beats == 250 || rx_beats == 750)
                begin
                    rx_hold_left = 600;
                end
            end
            if (rx_phase_left == 0)
            begin
                rx_style = $urandom_range(0, 3);
                rx_phase_left = $urandom_range(32, 256);
            end
            else
            begin
                rx_phase_left--;
            end
            if (rx_hold_left != 0)
            begin
                rx_hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case (rx_style)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= logic'($urandom_range(0, 1));
                    2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= (rx_phase_left % 5) != 0;
                endcase
            end
        end
    end

    // Prediction on every item beat, check on every result beat.
    ctl_item_t   seen_item;
    ctl_result_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result beat", result_ch.reactive_increment, 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_ch.reactive_increment !== want.increment)
                    begin
                        report_mismatch("reactive_increment", result_ch.reactive_increment,
                                        want.increment);
                    end
                    if (result_ch.status !== want.status)
                    begin
                        report_mismatch("status", result_ch.status, want.status);
                    end
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                seen_item.mode = item_ch.mode;
                seen_item.dt   = item_ch.delta_time;
                seen_item.volt = item_ch.terminal_voltage;
                seen_item.reac = item_ch.reactive_power;
                expected_results.push_back(predict_beat(seen_item));
            end
        end
    end

    // Main sequence: reset, then per phase program the registers while idle,
    // queue the beats and wait until every result is back.
    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.mode = MODE_INIT;
        item_ch.delta_time = '0;
        item_ch.terminal_voltage = '0;
        item_ch.reactive_power = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_REFERENCE_SELECT;
        cfg_ch.data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            @(posedge clk);
            build_phase_settings(ph);
            program_registers();
            if (ph == 0)
            begin
                queue_directed_items();
            end
            queue_random_items(PHASE_ITEMS);
            wait_for_drain();
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### plant_reactive_power_controller.f
rtl/core/prc_pkg.sv
rtl/core/prc_ifs.sv
rtl/core/prc_mul.sv
rtl/core/prc_regs.sv
rtl/core/prc_core.sv
rtl/core/plant_reactive_power_controller.sv
tb/sv/plant_reactive_power_controller_tb.sv
